FILE: src/assert_macros.svh
// assertion macros used by the checker file gmdp_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while out of reset
`define GMDP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("check failed");

// property checked at every edge, reset included
`define GMDP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("check failed");

`endif

FILE: src/gmdp_pkg.sv
// ----------------------------------------------------------------------------
// gmdp_pkg
// shared constants, types and control structs of the bf16 multi dot product
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gmdp_pkg;

    // number of slots in use and number of slots that exist
    localparam int SLOT_COUNT   = 4;
    localparam int LANES        = 4;
    localparam int ACTIVE_LANES = (SLOT_COUNT < LANES) ? SLOT_COUNT : LANES;

    // alignment window of the fused add
    localparam int WIN = 62;

    localparam logic [31:0] QNAN32 = 32'h7FC0_0000;
    localparam logic [31:0] INF32  = 32'h7F80_0000;

    // signed exponent arithmetic
    typedef logic signed [11:0] t_exp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_EXP,
        ST_ALIGN,
        ST_ADD,
        ST_LZC,
        ST_NORM,
        ST_ROUND,
        ST_PACK,
        ST_EMIT
    } t_state;

    // controller to datapath step strobes
    typedef struct packed {
        logic load;
        logic mul;
        logic expo;
        logic align;
        logic add;
        logic lzc;
        logic norm;
        logic rnd;
        logic pack;
        logic emit;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic last;
    } t_dp_status;

endpackage

FILE: src/gmdp_lane.sv
// ----------------------------------------------------------------------------
// gmdp_lane
// one fp32 accumulator lane: bf16 x bf16 fused multiply-add, stepped in stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gmdp_lane (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gmdp_pkg::t_dp_cmd i_cmd,
    input  logic [15:0]       i_grad,
    input  logic [15:0]       i_z,
    output logic [31:0]       o_acc
);
    import gmdp_pkg::*;

    localparam logic [WIN-1:0] ONE_W = WIN'(1);

    function automatic logic [4:0] bitlen24(input logic [23:0] x);
        logic [4:0] n;
        n = '0;
        for (int i = 0; i < 24; i++) begin
            if (x[i]) n = 5'(i + 1);
        end
        return n;
    endfunction

    function automatic logic [4:0] bitlen16(input logic [15:0] x);
        logic [4:0] n;
        n = '0;
        for (int i = 0; i < 16; i++) begin
            if (x[i]) n = 5'(i + 1);
        end
        return n;
    endfunction

    // place m * 2^e on the grid 2^w, dd = e - w, lost bits kept as sticky
    function automatic logic [WIN-1:0] align_to(input logic [23:0] m, input t_exp dd);
        logic [63:0] mw;
        logic [63:0] r;
        t_exp        d;
        mw = 64'(m);
        d  = -dd;
        if (dd >= 0) begin
            r = mw << dd[5:0];
        end else if (d >= 64) begin
            r = {63'b0, (m != '0)};
        end else begin
            r = mw >> d[5:0];
            if ((mw & ((64'd1 << d[5:0]) - 64'd1)) != '0) r[0] = 1'b1;
        end
        return r[WIN-1:0];
    endfunction

    logic [31:0]    r_acc;
    logic           r_spec;
    logic [31:0]    r_spec_val;
    logic [15:0]    r_mp;
    logic [23:0]    r_mc;
    t_exp           r_ep, r_ec, r_w, r_dp, r_dc, r_q, r_sh;
    logic           r_sp, r_sc, r_s, r_zero;
    logic [WIN-1:0] r_pv, r_cv, r_r;
    logic [4:0]     r_clen [4];
    logic [24:0]    r_kept;

    // operand unpack and special cases
    logic        sa, sb, sc, sp;
    logic [7:0]  xa, xb, xc;
    logic [6:0]  fa, fb;
    logic [22:0] fc;
    logic        a_inf, b_inf, c_inf, a_zero, b_zero, any_nan;
    logic [7:0]  ma, mb;
    logic [15:0] mp;
    logic [23:0] mc;
    t_exp        ea, eb, ec;
    logic        spec;
    logic [31:0] spec_val;

    always_comb begin
        sa = i_grad[15]; xa = i_grad[14:7]; fa = i_grad[6:0];
        sb = i_z[15];    xb = i_z[14:7];    fb = i_z[6:0];
        sc = r_acc[31];  xc = r_acc[30:23]; fc = r_acc[22:0];
        sp = sa ^ sb;
        a_inf  = (xa == 8'hFF) && (fa == '0);
        b_inf  = (xb == 8'hFF) && (fb == '0);
        c_inf  = (xc == 8'hFF) && (fc == '0);
        a_zero = (xa == '0) && (fa == '0);
        b_zero = (xb == '0) && (fb == '0);
        any_nan = ((xa == 8'hFF) && (fa != '0)) || ((xb == 8'hFF) && (fb != '0))
               || ((xc == 8'hFF) && (fc != '0));
        ma = {(xa != '0), fa};
        mb = {(xb != '0), fb};
        mc = {(xc != '0), fc};
        ea = (xa == '0) ? t_exp'(-133) : t_exp'({4'b0, xa}) - t_exp'(134);
        eb = (xb == '0) ? t_exp'(-133) : t_exp'({4'b0, xb}) - t_exp'(134);
        ec = (xc == '0) ? t_exp'(-149) : t_exp'({4'b0, xc}) - t_exp'(150);
        mp = 16'(ma) * 16'(mb);
        spec     = 1'b1;
        spec_val = QNAN32;
        if (any_nan) begin
            spec_val = QNAN32;
        end else if (a_inf || b_inf) begin
            if ((!a_inf && a_zero) || (!b_inf && b_zero)) begin
                spec_val = QNAN32;
            end else if (c_inf && (sc != sp)) begin
                spec_val = QNAN32;
            end else begin
                spec_val = {sp, INF32[30:0]};
            end
        end else if (c_inf) begin
            spec_val = {sc, INF32[30:0]};
        end else if (mp == '0) begin
            spec_val = (mc == '0) ? {(sp & sc), 31'b0} : r_acc;
        end else begin
            spec = 1'b0;
        end
    end

    // exponent of the top bit and shift amounts
    logic [4:0] lenp, lenc;
    t_exp       tp, tc, top, w;

    always_comb begin
        lenp = bitlen24(24'(r_mp));
        lenc = bitlen24(r_mc);
        tp   = r_ep + t_exp'(lenp);
        tc   = (r_mc != '0) ? r_ec + t_exp'(lenc) : tp;
        top  = (tp > tc) ? tp : tc;
        w    = top - t_exp'(60);
    end

    // signed add of the aligned terms
    logic [WIN-1:0] sum_r;
    logic           sum_s;

    always_comb begin
        if (r_sp == r_sc) begin
            sum_r = r_pv + r_cv;
            sum_s = r_sp;
        end else if (r_pv >= r_cv) begin
            sum_r = r_pv - r_cv;
            sum_s = r_sp;
        end else begin
            sum_r = r_cv - r_pv;
            sum_s = r_sc;
        end
    end

    // leading one per 16-bit chunk, combined in the next step
    logic [63:0] rr64;
    logic [6:0]  len;
    t_exp        q;

    always_comb begin
        rr64 = 64'(r_r);
        len  = '0;
        for (int j = 0; j < 4; j++) begin
            if (r_clen[j] != '0) len = 7'(16 * j) + 7'(r_clen[j]);
        end
        q = r_w + t_exp'(len) - t_exp'(24);
        if (q < t_exp'(-149)) q = t_exp'(-149);
    end

    // shift to 24 bits and round to nearest even
    t_exp           nsh;
    logic [5:0]     sh6, shm1;
    logic [WIN-1:0] shl, shr;
    logic           rbit, sticky;
    logic [24:0]    kept;

    always_comb begin
        nsh    = -r_sh;
        sh6    = r_sh[5:0];
        shm1   = sh6 - 6'd1;
        shl    = r_r << nsh[5:0];
        shr    = r_r >> sh6;
        rbit   = r_r[shm1];
        sticky = (r_r & ((ONE_W << shm1) - ONE_W)) != '0;
        if (r_sh <= 0) begin
            kept = shl[24:0];
        end else if (r_sh >= 63) begin
            kept = '0;
        end else begin
            kept = shr[24:0] + 25'(rbit & (sticky | shr[0]));
        end
    end

    // final pack with carry out of rounding and overflow
    logic [24:0] kept2;
    t_exp        q2, ev;
    logic [31:0] packed_val, acc_next;

    always_comb begin
        kept2 = r_kept;
        q2    = r_q;
        if (r_kept[24]) begin
            kept2 = r_kept >> 1;
            q2    = r_q + t_exp'(1);
        end
        ev = q2 + t_exp'(150);
        if (!kept2[23]) begin
            packed_val = {r_s, 8'b0, kept2[22:0]};
        end else if (ev >= t_exp'(255)) begin
            packed_val = {r_s, INF32[30:0]};
        end else begin
            packed_val = {r_s, ev[7:0], kept2[22:0]};
        end
        if (r_spec) acc_next = r_spec_val;
        else if (r_zero) acc_next = '0;
        else acc_next = packed_val;
    end

    // accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_cmd.emit) begin
            r_acc <= '0;
        end else if (i_cmd.pack) begin
            r_acc <= acc_next;
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_spec     <= spec;
            r_spec_val <= spec_val;
            r_mp       <= mp;
            r_mc       <= mc;
            r_ep       <= ea + eb;
            r_ec       <= ec;
            r_sp       <= sp;
            r_sc       <= sc;
        end
        if (i_cmd.expo) begin
            r_w  <= w;
            r_dp <= r_ep - w;
            r_dc <= r_ec - w;
        end
        if (i_cmd.align) begin
            r_pv <= align_to(24'(r_mp), r_dp);
            r_cv <= (r_mc != '0) ? align_to(r_mc, r_dc) : '0;
        end
        if (i_cmd.add) begin
            r_r <= sum_r;
            r_s <= sum_s;
        end
        if (i_cmd.lzc) begin
            for (int j = 0; j < 4; j++) begin
                r_clen[j] <= bitlen16(rr64[16*j +: 16]);
            end
        end
        if (i_cmd.norm) begin
            r_q    <= q;
            r_sh   <= q - r_w;
            r_zero <= (len == '0);
        end
        if (i_cmd.rnd) begin
            r_kept <= kept;
        end
    end

    assign o_acc = r_acc;

endmodule

FILE: src/gmdp_datapath.sv
// ----------------------------------------------------------------------------
// gmdp_datapath
// input beat registers, accumulator lanes and the result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gmdp_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  gmdp_pkg::t_dp_cmd                   i_cmd,
    input  logic [15:0]                         i_grad,
    input  logic [gmdp_pkg::LANES-1:0][15:0]    i_z,
    input  logic                                i_last,
    output gmdp_pkg::t_dp_status                o_status,
    output logic [gmdp_pkg::LANES-1:0][31:0]    o_sum
);
    import gmdp_pkg::*;

    logic [15:0]            r_grad;
    logic                   r_last;
    logic [LANES-1:0][31:0] acc;
    logic [LANES-1:0][31:0] r_sum;

    // input beat capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_grad <= i_grad;
            r_last <= i_last;
        end
    end

    // active lanes compute, the rest read as +0
    for (genvar k = 0; k < LANES; k++) begin : g_lane
        if (k < ACTIVE_LANES) begin : g_on
            logic [15:0] r_z;
            always_ff @(posedge i_clk) begin
                if (i_cmd.load) r_z <= i_z[k];
            end
            gmdp_lane u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (i_cmd),
                .i_grad  (r_grad),
                .i_z     (r_z),
                .o_acc   (acc[k])
            );
        end else begin : g_off
            assign acc[k] = '0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) r_sum <= acc;
    end

    assign o_status.last = r_last;
    assign o_sum         = r_sum;

endmodule

FILE: src/gmdp_ctrl.sv
// ----------------------------------------------------------------------------
// gmdp_ctrl
// sequencer of the fused multiply-add steps and the output handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gmdp_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    output logic                 o_valid,
    input  logic                 i_stall,
    input  gmdp_pkg::t_dp_status i_status,
    output gmdp_pkg::t_dp_cmd    o_cmd
);
    import gmdp_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // state and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and step strobes
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_EXP;
            end
            ST_EXP: begin
                o_cmd.expo = 1'b1;
                n_state    = ST_ALIGN;
            end
            ST_ALIGN: begin
                o_cmd.align = 1'b1;
                n_state     = ST_ADD;
            end
            ST_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = ST_LZC;
            end
            ST_LZC: begin
                o_cmd.lzc = 1'b1;
                n_state   = ST_NORM;
            end
            ST_NORM: begin
                o_cmd.norm = 1'b1;
                n_state    = ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd.rnd = 1'b1;
                n_state   = ST_PACK;
            end
            ST_PACK: begin
                o_cmd.pack = 1'b1;
                n_state    = i_status.last ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // output beat valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_stall) n_out_valid = 1'b0;
        if (o_cmd.emit) n_out_valid = 1'b1;
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;

endmodule

FILE: src/gathered_multi_dot_product_bf16.sv
// ----------------------------------------------------------------------------
// gathered_multi_dot_product_bf16
// four bf16 dot products against one gradient vector, fp32 accumulation
// ----------------------------------------------------------------------------
// usage
//   input channel: i_valid / o_stall, one beat carries a gradient element,
//   the matching element of each of the four slots and the last flag
//   output channel: o_valid / i_stall, one beat carries the four fp32 sums
//   and is sent only for an input beat marked last
// timing
//   each beat runs through an eight-step fused multiply-add sequence shared
//   by the four lanes, and a new beat is taken only once that sequence ends
//   a last beat adds an emit step that moves the sums into the output register
// reset
//   accumulators return to +0.0, the output register is empty
// stalls
//   a waiting result holds in the output register while further beats are
//   taken; a new last beat waits in its final step until that result leaves
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gathered_multi_dot_product_bf16 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_grad_value,
    input  logic [15:0] i_z_slot0,
    input  logic [15:0] i_z_slot1,
    input  logic [15:0] i_z_slot2,
    input  logic [15:0] i_z_slot3,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_sum_slot0,
    output logic [31:0] o_sum_slot1,
    output logic [31:0] o_sum_slot2,
    output logic [31:0] o_sum_slot3
);
    import gmdp_pkg::*;

    t_dp_cmd                cmd;
    t_dp_status             status;
    logic [LANES-1:0][31:0] sum;

    gmdp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    gmdp_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_grad   (i_grad_value),
        .i_z      ({i_z_slot3, i_z_slot2, i_z_slot1, i_z_slot0}),
        .i_last   (i_last),
        .o_status (status),
        .o_sum    (sum)
    );

    assign o_sum_slot0 = sum[0];
    assign o_sum_slot1 = sum[1];
    assign o_sum_slot2 = sum[2];
    assign o_sum_slot3 = sum[3];

endmodule

FILE: src/gmdp_checker.sv
// ----------------------------------------------------------------------------
// gmdp_checker
// port-level checks of the dot product block, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gmdp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [15:0] i_grad_value,
    input logic [15:0] i_z_slot0,
    input logic [15:0] i_z_slot1,
    input logic [15:0] i_z_slot2,
    input logic [15:0] i_z_slot3,
    input logic        i_last,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_sum_slot0,
    input logic [31:0] o_sum_slot1,
    input logic [31:0] o_sum_slot2,
    input logic [31:0] o_sum_slot3
);

    // a stalled result beat stays valid
    `GMDP_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid)

    // reset leaves the output empty
    `GMDP_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_valid)

    // an accepted beat keeps the block busy in the next cycle
    `GMDP_ASSERT(a_busy_after, i_clk, i_rst_n, i_valid && !o_stall |=> o_stall)

    // a result appears only out of a busy sequence
    `GMDP_ASSERT(a_rise_busy, i_clk, i_rst_n, $rose(o_valid) |-> $past(o_stall))

endmodule

bind gathered_multi_dot_product_bf16 gmdp_checker u_gmdp_checker (.*);

FILE: sim/gathered_multi_dot_product_bf16_test.sv
// ----------------------------------------------------------------------------
// gathered_multi_dot_product_bf16_test
// checks the four-lane bf16 dot product against a bit-exact fp32 fma predictor
// ----------------------------------------------------------------------------
// beats are sent through the valid/stall input channel: a directed set of
// corner cases comes first, then random vectors under several idle and stall
// mixes. Each accepted beat runs through the predictor; every beat marked
// last queues the four expected sums, which are compared with each result
// beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gathered_multi_dot_product_bf16_test;
    import gmdp_pkg::*;

    typedef logic [3:0][31:0] t_sums;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [15:0] i_grad_value;
    logic [15:0] i_z_slot0;
    logic [15:0] i_z_slot1;
    logic [15:0] i_z_slot2;
    logic [15:0] i_z_slot3;
    logic        i_last;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_sum_slot0;
    logic [31:0] o_sum_slot1;
    logic [31:0] o_sum_slot2;
    logic [31:0] o_sum_slot3;

    t_sums       expected_sums[$];
    logic [31:0] lane_sum[LANES];
    int          idle_pct;
    int          stall_pct;
    int          hold_req;
    int          hold_seen;
    int          hold_cnt;
    int          mismatches;

    gathered_multi_dot_product_bf16 dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_grad_value (i_grad_value),
        .i_z_slot0    (i_z_slot0),
        .i_z_slot1    (i_z_slot1),
        .i_z_slot2    (i_z_slot2),
        .i_z_slot3    (i_z_slot3),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_sum_slot0  (o_sum_slot0),
        .o_sum_slot1  (o_sum_slot1),
        .o_sum_slot2  (o_sum_slot2),
        .o_sum_slot3  (o_sum_slot3)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("[gathered_multi_dot_product_bf16] ERROR");
        $finish;
    end

    function automatic int bit_len(logic [63:0] x);
        int n;
        n = 0;
        while (x != 0) begin
            n++;
            x = x >> 1;
        end
        return n;
    endfunction

    // place m * 2^e on the grid 2^w, lost bits fold into a sticky lsb
    function automatic logic [63:0] to_grid(logic [63:0] m, int e, int w);
        int          d;
        logic [63:0] r;
        if (e >= w) return m << (e - w);
        d = w - e;
        if (d >= 64) return (m != 0) ? 64'd1 : 64'd0;
        r = m >> d;
        if ((m & ((64'd1 << d) - 64'd1)) != 0) r[0] = 1'b1;
        return r;
    endfunction

    // round sign, r * 2^w to fp32, nearest even
    function automatic logic [31:0] round_fp32(logic s, logic [63:0] r, int w);
        int          q;
        int          sh;
        logic [63:0] kept;
        logic [63:0] rem;
        logic [63:0] half;
        q = w + bit_len(r) - 24;
        if (q < -149) q = -149;
        sh = q - w;
        if (sh <= 0) begin
            kept = r << (-sh);
        end else if (sh >= 63) begin
            kept = 0;
        end else begin
            rem  = r & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            kept = r >> sh;
            if (rem > half || (rem == half && kept[0])) kept++;
        end
        if (kept >= (64'd1 << 24)) begin
            kept = kept >> 1;
            q++;
        end
        if (kept < (64'd1 << 23)) return {s, kept[30:0]};
        if (q + 150 >= 255) return {s, INF32[30:0]};
        return {s, 8'(q + 150), kept[22:0]};
    endfunction

    // a * b + c with bf16 a, b and fp32 c, single rounding
    function automatic logic [31:0] bf16_fma(logic [15:0] a, logic [15:0] b, logic [31:0] c);
        logic        sp;
        logic        s;
        logic        a_inf;
        logic        b_inf;
        logic        c_inf;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] mc;
        logic [63:0] mp;
        logic [63:0] pv;
        logic [63:0] cv;
        logic [63:0] r;
        int          ea;
        int          eb;
        int          ec;
        int          ep;
        int          tp;
        int          tc;
        int          w;
        sp    = a[15] ^ b[15];
        a_inf = a[14:7] == 8'hFF && a[6:0] == 0;
        b_inf = b[14:7] == 8'hFF && b[6:0] == 0;
        c_inf = c[30:23] == 8'hFF && c[22:0] == 0;
        if ((a[14:7] == 8'hFF && a[6:0] != 0) || (b[14:7] == 8'hFF && b[6:0] != 0)
            || (c[30:23] == 8'hFF && c[22:0] != 0)) return QNAN32;
        if (a_inf || b_inf) begin
            if ((!a_inf && a[14:0] == 0) || (!b_inf && b[14:0] == 0)) return QNAN32;
            if (c_inf && c[31] != sp) return QNAN32;
            return {sp, INF32[30:0]};
        end
        if (c_inf) return c;
        ma = (a[14:7] == 0) ? {57'd0, a[6:0]} : {56'd0, 1'b1, a[6:0]};
        ea = (a[14:7] == 0) ? -133 : int'(a[14:7]) - 134;
        mb = (b[14:7] == 0) ? {57'd0, b[6:0]} : {56'd0, 1'b1, b[6:0]};
        eb = (b[14:7] == 0) ? -133 : int'(b[14:7]) - 134;
        mc = (c[30:23] == 0) ? {41'd0, c[22:0]} : {40'd0, 1'b1, c[22:0]};
        ec = (c[30:23] == 0) ? -149 : int'(c[30:23]) - 150;
        mp = ma * mb;
        ep = ea + eb;
        if (mp == 0) begin
            if (mc == 0) return {sp & c[31], 31'd0};
            return c;
        end
        tp = ep + bit_len(mp);
        tc = (mc != 0) ? ec + bit_len(mc) : tp;
        w  = ((tp > tc) ? tp : tc) - 60;
        pv = to_grid(mp, ep, w);
        cv = (mc != 0) ? to_grid(mc, ec, w) : 64'd0;
        if (sp == c[31]) begin
            r = pv + cv;
            s = sp;
        end else if (pv >= cv) begin
            r = pv - cv;
            s = sp;
        end else begin
            r = cv - pv;
            s = c[31];
        end
        if (r == 0) return 32'd0;
        return round_fp32(s, r, w);
    endfunction

    // accumulate one accepted beat, queue the sums on last
    task automatic accumulate_beat(logic [15:0] g, logic [3:0][15:0] z, logic last);
        t_sums sums;
        for (int k = 0; k < ACTIVE_LANES; k++) lane_sum[k] = bf16_fma(g, z[k], lane_sum[k]);
        if (last) begin
            for (int k = 0; k < LANES; k++) begin
                sums[k]     = lane_sum[k];
                lane_sum[k] = 32'd0;
            end
            expected_sums.push_back(sums);
        end
    endtask

    // send one beat, with random idle cycles ahead of it
    task automatic send_beat(logic [15:0] g, logic [3:0][15:0] z, logic last);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_grad_value <= g;
        i_z_slot0    <= z[0];
        i_z_slot1    <= z[1];
        i_z_slot2    <= z[2];
        i_z_slot3    <= z[3];
        i_last       <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        accumulate_beat(g, z, last);
    endtask

    // bf16 values biased toward finite numbers of similar scale
    function automatic logic [15:0] rand_bf16();
        int pick;
        pick = $urandom_range(99);
        if (pick < 65) return {1'($urandom), 8'($urandom_range(140, 112)), 7'($urandom)};
        if (pick < 73) return {1'($urandom), 15'd0};
        if (pick < 77) return {1'($urandom), 8'hFF, 7'd0};
        if (pick < 80) return {1'($urandom), 8'hFF, 7'($urandom_range(127, 1))};
        if (pick < 86) return {1'($urandom), 8'd0, 7'($urandom)};
        if (pick < 90) return {1'($urandom), 8'($urandom_range(254, 240)), 7'($urandom)};
        return 16'($urandom);
    endfunction

    task automatic send_vector(int len);
        logic [3:0][15:0] z;
        for (int i = 0; i < len; i++) begin
            for (int k = 0; k < 4; k++) z[k] = rand_bf16();
            send_beat(rand_bf16(), z, i == len - 1);
        end
    endtask

    // field extremes, nan and infinity rules, overflow, cancellation, subnormals
    task automatic test_directed();
        idle_pct  = 0;
        stall_pct = 0;
        send_beat(16'h0000, {4{16'h0000}}, 1'b1);
        send_beat(16'hFFFF, {4{16'hFFFF}}, 1'b1);
        send_beat(16'h7F80, {16'h0000, 16'h8000, 16'h3F80, 16'hBF80}, 1'b0);
        send_beat(16'hFF80, {16'h3F80, 16'h3F80, 16'h3F80, 16'h3F80}, 1'b1);
        send_beat(16'h7F7F, {16'h7F7F, 16'hFF7F, 16'h7F00, 16'h3F80}, 1'b0);
        send_beat(16'h7F7F, {16'h7F7F, 16'hFF7F, 16'h7F00, 16'h3F80}, 1'b1);
        send_beat(16'h4040, {16'h3FC0, 16'hBFC0, 16'h4000, 16'h0001}, 1'b0);
        send_beat(16'hC040, {16'h3FC0, 16'hBFC0, 16'h4000, 16'h0001}, 1'b1);
        send_beat(16'h8000, {16'h0000, 16'h8000, 16'h0001, 16'h807F}, 1'b1);
        send_beat(16'h0001, {16'h0001, 16'h007F, 16'h3F80, 16'h0080}, 1'b0);
        send_beat(16'h0080, {16'h8001, 16'h3F81, 16'hBF80, 16'h00FF}, 1'b1);
        send_beat(16'h3F80, {16'h7FC0, 16'h7F81, 16'h7F80, 16'hFF80}, 1'b1);
        send_beat(16'h5555, {16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}, 1'b0);
        send_beat(16'hAAAA, {16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA}, 1'b1);
        send_beat(16'h3F80, {16'h4B80, 16'h3F80, 16'h0000, 16'h0000}, 1'b0);
        send_beat(16'h3F80, {16'h3F80, 16'h3380, 16'h0000, 16'h0000}, 1'b1);
    endtask

    task automatic test_random(int beats, int idle, int stall);
        int sent;
        int len;
        idle_pct  = idle;
        stall_pct = stall;
        sent      = 0;
        while (sent < beats) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
            send_vector(len);
            sent += len;
        end
    endtask

    // long receiver hold while short vectors keep coming, so the input backs up
    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        hold_req++;
        repeat (12) send_vector($urandom_range(3, 1));
    endtask

    // sender waits for every result before going on
    task automatic test_pause();
        idle_pct  = 10;
        stall_pct = 30;
        send_vector(5);
        i_valid <= 1'b0;
        wait (expected_sums.size() == 0);
        @(posedge i_clk);
        send_vector(6);
    endtask

    // receiver stall, with an occasional long hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_cnt  <= 300;
            i_stall   <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_stall  <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // result check against the oldest queued sums
    always @(posedge i_clk) begin
        t_sums got;
        t_sums want;
        got = {o_sum_slot3, o_sum_slot2, o_sum_slot1, o_sum_slot0};
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_sums.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat: %h", got);
            end else begin
                want = expected_sums.pop_front();
                for (int k = 0; k < LANES; k++) begin
                    if (got[k] !== want[k]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("sum_slot%0d: expected %h, actual %h", k, want[k], got[k]);
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_stall      = 1'b0;
        i_grad_value = 16'd0;
        i_z_slot0    = 16'd0;
        i_z_slot1    = 16'd0;
        i_z_slot2    = 16'd0;
        i_z_slot3    = 16'd0;
        i_last       = 1'b0;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_req     = 0;
        hold_seen    = 0;
        hold_cnt     = 0;
        mismatches   = 0;
        for (int k = 0; k < LANES; k++) lane_sum[k] = 32'd0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(220, 0, 0);
        test_random(220, 65, 0);
        test_random(220, 0, 65);
        test_random(220, 16, 16);
        test_backpressure();
        test_pause();

        // drain
        i_valid <= 1'b0;
        wait (expected_sums.size() == 0);
        repeat (30) @(posedge i_clk);
        if (mismatches == 0 && expected_sums.size() == 0)
            $display("[gathered_multi_dot_product_bf16] OK");
        else
            $display("[gathered_multi_dot_product_bf16] ERROR");
        $finish;
    end

endmodule
